// File: rtl/core/positional_list_insert_delete_assert.svh
// ----------------------------------------------------------------------------
// positional_list_insert_delete_assert
// Assertion macros for the positional list block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTHESIS
`define PLID_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plid assertion failed");
`define PLID_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plid assertion failed");
`else
`define PLID_ASSERT_IMP(lbl, ante, cons)
`define PLID_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Shared constants and types of the positional list block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plid_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int LEN_W  = 5;
	localparam int ACT_W  = 2;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int ST_W   = 2;
	localparam int CMP_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
	localparam int IN_W   = ((ACT_W + POS_W + DATA_W + 7) / 8) * 8;
	localparam int OUT_W  = ((ST_W + DATA_W + LEN_W + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic             rd;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [LEN_W-1:0] len_after;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/core/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed words with insert, delete and read by position.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one operation per transaction (insert, delete
//   or read at a one-based position). Master channel m_* returns exactly one
//   result per operation: status, element and the length after the step.
//   m_tvalid rises in the cycle after the input transaction. One operation
//   is taken per cycle while results are taken: a row of DEPTH cells shifts
//   the words from the given position on by one place in the same clock, so
//   the rate is set by that single cell update plus the element select.
//   The result sits in an output register; while the receiver stalls, a new
//   operation is taken in the cycle the held result is taken (s_tready
//   follows m_tready when a result is pending).
//   Reset empties the list and drops any pending result; no clearing pass is
//   needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_insert_delete_assert.svh"

module positional_list_insert_delete import plid_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // action[1:0], position[6:2], value[38:7]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata   // status[1:0], element[33:2], length_after[38:34]
);

	logic [ACT_W-1:0]         action;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     fire;
	cmd_t                     cmd;
	res_t                     res;
	logic [LEN_W-1:0]         len_q;
	logic signed [DATA_W-1:0] cells [DEPTH];
	logic signed [DATA_W-1:0] element;
	logic                     m_valid_q;
	logic [OUT_W-1:0]         m_data_q;

	assign action   = s_tdata[ACT_W-1:0];
	assign position = s_tdata[ACT_W +: POS_W];
	assign value    = s_tdata[ACT_W+POS_W +: DATA_W];

	assign s_tready = !m_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	plid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.action   (action),
		.position (position),
		.cmd      (cmd),
		.res      (res),
		.len_q    (len_q)
	);

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cells[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cells[g+1];
		end
		plid_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.cell_idx (IDX_W'(g)),
			.value    (value),
			.left     (left_w),
			.right    (right_w),
			.data_q   (cells[g])
		);
	end

	assign element = cmd.rd ? cells[cmd.idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_data_q <= OUT_W'({res.len_after, element, res.status});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	`PLID_ASSERT_IMP(a_len_bound, 1'b1, len_q <= LEN_W'(DEPTH))
	`PLID_ASSERT_NXT(a_err_keeps_len, fire && res.status != ST_DONE, $stable(len_q))
	`PLID_ASSERT_NXT(a_ins_grows, fire && action == ACT_INSERT && res.status == ST_DONE,
		len_q == $past(len_q) + LEN_W'(1))
	`PLID_ASSERT_NXT(a_result_follows, fire, m_tvalid)

endmodule

`default_nettype wire

// File: rtl/core/plid_cell.sv
// ----------------------------------------------------------------------------
// plid_cell
// One list slot: loads the new value, or takes a neighbor on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plid_cell import plid_pkg::*; (
	input  wire logic                     clk,
	input  wire cmd_t                     cmd,
	input  wire logic [IDX_W-1:0]         cell_idx,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic signed [DATA_W-1:0] left,
	input  wire logic signed [DATA_W-1:0] right,
	output logic signed [DATA_W-1:0]      data_q
);

	always_ff @(posedge clk) begin
		priority if (cmd.ins && cell_idx == cmd.idx) begin
			data_q <= value;
		end else if (cmd.ins && cell_idx > cmd.idx) begin
			data_q <= left;
		end else if (cmd.del && cell_idx >= cmd.idx) begin
			data_q <= right;
		end else begin
			data_q <= data_q;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/plid_ctrl.sv
// ----------------------------------------------------------------------------
// plid_ctrl
// Range checks, status, length register and the command broadcast to cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plid_ctrl import plid_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic [ACT_W-1:0] action,
	input  wire logic [POS_W-1:0] position,
	output cmd_t                  cmd,
	output res_t                  res,
	output logic [LEN_W-1:0]      len_q
);

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] len_x;
	logic [CMP_W-1:0] pos_m1;
	logic             ins_ok;
	logic             rd_ok;
	logic             full;
	logic [LEN_W-1:0] len_nxt;

	assign pos_x  = CMP_W'(position);
	assign len_x  = CMP_W'(len_q);
	assign pos_m1 = pos_x - CMP_W'(1);
	assign ins_ok = (position != '0) && (pos_x <= len_x + CMP_W'(1));
	assign rd_ok  = (position != '0) && (pos_x <= len_x);
	assign full   = (len_x == CMP_W'(DEPTH));

	always_comb begin
		cmd        = '0;
		cmd.idx    = IDX_W'(pos_m1);
		res.status = ST_DONE;
		len_nxt    = len_q;
		unique case (action)
			ACT_INSERT: begin
				if (!ins_ok) begin
					res.status = ST_RANGE;
				end else if (full) begin
					res.status = ST_FULL;
				end else begin
					cmd.ins = fire;
					len_nxt = len_q + LEN_W'(1);
				end
			end
			ACT_DELETE: begin
				if (!rd_ok) begin
					res.status = ST_RANGE;
				end else begin
					cmd.del = fire;
					cmd.rd  = 1'b1;
					len_nxt = len_q - LEN_W'(1);
				end
			end
			ACT_READ: begin
				if (!rd_ok) begin
					res.status = ST_RANGE;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.len_after = len_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (fire) begin
			len_q <= len_nxt;
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/positional_list_checker.sv
// ----------------------------------------------------------------------------
// positional_list_checker
// Watches both stream channels of the positional list, tracks the list
// contents from every accepted operation and compares each returned result,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_checker import plid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] element;
		logic [LEN_W-1:0]  length_after;
	} list_result_t;

	logic [DATA_W-1:0] list_words [DEPTH];
	int                list_len;
	list_result_t      outstanding [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	// next state of the list plus the result the operation must return
	function automatic list_result_t apply_list_op(input logic [ACT_W-1:0] act,
			input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] val);
		list_result_t r;
		int           p;
		int           i;
		r.status  = ST_DONE;
		r.element = '0;
		p = pos;
		case (act)
			ACT_INSERT: begin
				if (p < 1 || p > list_len + 1) begin
					r.status = ST_RANGE;
				end else if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i >= p; i--)
						list_words[i] = list_words[i-1];
					list_words[p-1] = val;
					list_len++;
				end
			end
			ACT_DELETE: begin
				if (p < 1 || p > list_len) begin
					r.status = ST_RANGE;
				end else begin
					r.element = list_words[p-1];
					for (i = p - 1; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			ACT_READ: begin
				if (p < 1 || p > list_len)
					r.status = ST_RANGE;
				else
					r.element = list_words[p-1];
			end
			default: ;
		endcase
		r.length_after = list_len[LEN_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			list_len = 0;
			outstanding.delete();
			pending = 0;
		end else begin
			// a result taken now belongs to an earlier operation: check before predicting
			if (m_tvalid && m_tready) begin
				if (outstanding.size() == 0) begin
					report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
				end else begin
					want = outstanding.pop_front();
					if (m_tdata[ST_W-1:0] !== want.status)
						report_mismatch("status", 64'(m_tdata[ST_W-1:0]), 64'(want.status));
					if (m_tdata[ST_W +: DATA_W] !== want.element)
						report_mismatch("element", 64'(m_tdata[ST_W +: DATA_W]),
							64'(want.element));
					if (m_tdata[ST_W+DATA_W +: LEN_W] !== want.length_after)
						report_mismatch("length_after", 64'(m_tdata[ST_W+DATA_W +: LEN_W]),
							64'(want.length_after));
				end
			end
			if (s_tvalid && s_tready)
				outstanding.push_back(apply_list_op(s_tdata[ACT_W-1:0],
					s_tdata[ACT_W +: POS_W], s_tdata[ACT_W+POS_W +: DATA_W]));
			pending = outstanding.size();
		end
	end

endmodule

// File: tb/sv/positional_list_insert_delete_tb.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb
// Drives insert, delete and read operations into the positional list: a
// directed pass over empty, full and out-of-range cases, then random
// operation streams that grow and drain the list under varying backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_insert_delete_tb;
	import plid_pkg::*;

	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
	localparam int RANDOM_OPS = 350;
	localparam int HOLD_CYCLES = 80;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;  // action[1:0], position[6:2], value[38:7]
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;       // status[1:0], element[33:2], length_after[38:34]

	int errors;
	int pending;
	int send_idle_pct = 25;
	int recv_idle_pct = 67;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int list_fill = 0;
	bit grow = 1'b1;

	logic [DATA_W-1:0] edge_vals [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
		32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};

	positional_list_insert_delete dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	positional_list_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_op(input logic [ACT_W-1:0] act, input int pos,
			input logic [DATA_W-1:0] val);
		if (act == ACT_INSERT && pos >= 1 && pos <= list_fill + 1 && list_fill < DEPTH)
			list_fill++;
		else if (act == ACT_DELETE && pos >= 1 && pos <= list_fill)
			list_fill--;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W-ACT_W-POS_W-DATA_W){1'b0}}, val, pos[POS_W-1:0], act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 9) == 0)
			return edge_vals[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	// mostly valid operations; the list drifts between empty and full
	task automatic send_random_op();
		int               r;
		logic [ACT_W-1:0] act;
		int               pos;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			send_op(ACT_W'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom);
		end else begin
			if (list_fill == 0)
				grow = 1'b1;
			else if (list_fill == DEPTH && $urandom_range(0, 3) == 0)
				grow = 1'b0;
			else if ($urandom_range(0, 49) == 0)
				grow = ~grow;
			r = $urandom_range(0, 99);
			if (list_fill == 0 || (r >= 30 && (grow ? r < 85 : r < 45)))
				act = ACT_INSERT;
			else if (r < 30)
				act = ACT_READ;
			else
				act = ACT_DELETE;
			if (act == ACT_INSERT)
				pos = $urandom_range(1, list_fill + 1);
			else
				pos = $urandom_range(1, list_fill);
			send_op(act, pos, pick_value());
		end
	endtask

	task automatic drain_wait();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int k;
		int ph;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list: nothing to read or delete, only position 1 is insertable
		send_op(ACT_READ, 1, 32'h0);
		send_op(ACT_DELETE, 1, 32'h0);
		send_op(ACT_INSERT, 0, 32'h1234_5678);
		send_op(ACT_INSERT, 2, 32'h1234_5678);
		// fill up: head, tail and middle inserts
		for (k = 0; k < DEPTH; k++) begin
			if (k % 3 == 0)
				send_op(ACT_INSERT, 1, k < 6 ? edge_vals[k] : $urandom);
			else if (k % 3 == 1)
				send_op(ACT_INSERT, list_fill + 1, k < 6 ? edge_vals[k] : $urandom);
			else
				send_op(ACT_INSERT, list_fill / 2 + 1, k < 6 ? edge_vals[k] : $urandom);
		end
		// full list: valid position reports full, bad position reports range
		send_op(ACT_INSERT, DEPTH + 1, 32'hDEAD_BEEF);
		send_op(ACT_INSERT, DEPTH + 2, 32'hDEAD_BEEF);
		send_op(ACT_INSERT, 31, 32'hDEAD_BEEF);
		send_op(ACT_READ, DEPTH, 32'h0);
		send_op(ACT_READ, DEPTH + 1, 32'h0);
		send_op(ACT_NONE, 5, 32'hFFFF_FFFF);
		send_op(ACT_DELETE, DEPTH, 32'h0);
		send_op(ACT_DELETE, 1, 32'h0);
		send_op(ACT_DELETE, 0, 32'h0);
		drain_wait();

		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 67 : 0;
			recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 25 : 0;
			for (k = 0; k < RANDOM_OPS; k++) begin
				if (k == 100 && ph != 1)
					hold_seq++;
				send_random_op();
			end
			drain_wait();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: positional_list_insert_delete.f
+incdir+rtl/core
rtl/core/plid_pkg.sv
rtl/core/plid_cell.sv
rtl/core/plid_ctrl.sv
rtl/core/positional_list_insert_delete.sv
tb/sv/positional_list_checker.sv
tb/sv/positional_list_insert_delete_tb.sv
